[rtl/mbdct_pkg.sv]
// mbdct_pkg: shared types and constants for the mouse button double-click tracker
// no dependencies; imported by the interfaces and all tracker modules
`default_nettype none

package mbdct_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned PosW       = 16;
  localparam int unsigned WindowW    = 16;

  // double-click window after reset, in ticks
  localparam logic [WindowW-1:0] WindowRst = 16'd500;

  // action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_LEVEL  = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_FRAME  = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  // per-button flag set
  typedef struct packed {
    logic dbl;
    logic allowed;
    logic waiting;
    logic latched;
    logic released;
    logic pressed;
    logic held;
  } btn_flags_t;

  // one registered input transaction
  typedef struct packed {
    logic [1:0]             action;
    logic [1:0]             button;
    logic                   level;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic                   scroll_up;
    logic                   scroll_down;
    logic                   clear_pressed;
    logic                   clear_released;
    logic                   clear_held;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [NumButtons-1:0] pressed_mask;
    logic [NumButtons-1:0] released_mask;
    logic [NumButtons-1:0] held_mask;
    logic [NumButtons-1:0] double_click_mask;
    logic                  wheel_up;
    logic                  wheel_down;
  } result_t;

endpackage

`default_nettype wire

[rtl/mbdct_in_if.sv]
// mbdct_in_if: valid/ready channel carrying one tracker input transaction
// depends on mbdct_pkg for field widths
`default_nettype none

interface mbdct_in_if
  import mbdct_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [1:0]             button;
  logic                   level;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic                   scroll_up;
  logic                   scroll_down;
  logic                   clear_pressed;
  logic                   clear_released;
  logic                   clear_held;

  modport source (
    output valid, action, button, level, pos_x, pos_y, scroll_up, scroll_down,
           clear_pressed, clear_released, clear_held,
    input  ready
  );

  modport sink (
    input  valid, action, button, level, pos_x, pos_y, scroll_up, scroll_down,
           clear_pressed, clear_released, clear_held,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mbdct_out_if.sv]
// mbdct_out_if: valid/ready channel carrying one tracker result transaction
// depends on mbdct_pkg for field widths
`default_nettype none

interface mbdct_out_if
  import mbdct_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [NumButtons-1:0] pressed_mask;
  logic [NumButtons-1:0] released_mask;
  logic [NumButtons-1:0] held_mask;
  logic [NumButtons-1:0] double_click_mask;
  logic                  wheel_up;
  logic                  wheel_down;

  modport source (
    output valid, pressed_mask, released_mask, held_mask, double_click_mask,
           wheel_up, wheel_down,
    input  ready
  );

  modport sink (
    input  valid, pressed_mask, released_mask, held_mask, double_click_mask,
           wheel_up, wheel_down,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mbdct_in_stage.sv]
// mbdct_in_stage: input register for tracker transactions
// depends on mbdct_pkg and mbdct_in_if
`default_nettype none

module mbdct_in_stage
  import mbdct_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mbdct_in_if.sink    in_i,
  input  wire logic   advance_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // free when empty or when the held transaction moves on this cycle
  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.action         <= in_i.action;
      item_q.button         <= in_i.button;
      item_q.level          <= in_i.level;
      item_q.pos_x          <= in_i.pos_x;
      item_q.pos_y          <= in_i.pos_y;
      item_q.scroll_up      <= in_i.scroll_up;
      item_q.scroll_down    <= in_i.scroll_down;
      item_q.clear_pressed  <= in_i.clear_pressed;
      item_q.clear_released <= in_i.clear_released;
      item_q.clear_held     <= in_i.clear_held;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[rtl/mbdct_update.sv]
// mbdct_update: button, tick, position and scroll state with its update logic
// depends on mbdct_pkg; produces the result of the transaction being applied
`default_nettype none

module mbdct_update
  import mbdct_pkg::*;
#(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WindowW-1:0] cfg_wdata_i,
  input  wire logic               apply_i,
  input  wire item_t              item_i,
  output result_t                 result_o
);

  localparam int unsigned TickW = TICK_COUNT_BITS;
  localparam int unsigned CmpW  = (TickW > WindowW) ? TickW : WindowW;

  btn_flags_t             flags_q [NumButtons];
  btn_flags_t             flags_d [NumButtons];
  logic [TickW-1:0]       ticks_q [NumButtons];
  logic [TickW-1:0]       ticks_d [NumButtons];
  logic signed [PosW-1:0] rel_x_q, rel_x_d;
  logic signed [PosW-1:0] rel_y_q, rel_y_d;
  logic                   scr_up_q, scr_up_d;
  logic                   scr_dn_q, scr_dn_d;
  logic [WindowW-1:0]     window_q;
  logic [CmpW-1:0]        window_ext;
  logic                   pos_match;

  assign window_ext = CmpW'(window_q);
  assign pos_match  = (rel_x_q == item_i.pos_x) && (rel_y_q == item_i.pos_y);

  // next state for the transaction in the input register
  always_comb begin
    btn_flags_t      f;
    logic [CmpW-1:0] t_ext;
    for (int b = 0; b < NumButtons; b++) begin
      flags_d[b] = flags_q[b];
      ticks_d[b] = ticks_q[b];
    end
    rel_x_d  = rel_x_q;
    rel_y_d  = rel_y_q;
    scr_up_d = scr_up_q;
    scr_dn_d = scr_dn_q;
    f        = '0;
    t_ext    = '0;

    case (action_e'(item_i.action))
      ACT_LEVEL: begin
        for (int b = 0; b < NumButtons; b++) begin
          if (item_i.button == 2'(b)) begin
            f     = flags_q[b];
            t_ext = CmpW'(ticks_q[b]);
            f.held = item_i.level;
            if (!f.latched) begin
              f.pressed = item_i.level;
            end
            f.released = !item_i.level;
            f.latched  = item_i.level;
            if (f.released) begin
              // release: arm the wait on the second release, store position
              if (f.allowed) begin
                f.waiting = 1'b1;
                rel_x_d   = item_i.pos_x;
                rel_y_d   = item_i.pos_y;
              end else begin
                f.allowed = 1'b1;
              end
              ticks_d[b] = '0;
            end else if (f.pressed && f.waiting) begin
              // press during a wait: check window and position
              if ((t_ext < window_ext) && pos_match) begin
                f.dbl = 1'b1;
              end
              f.waiting = 1'b0;
              f.allowed = 1'b0;
            end
            flags_d[b] = f;
          end
        end
      end
      ACT_SCROLL: begin
        scr_up_d = item_i.scroll_up;
        scr_dn_d = item_i.scroll_down;
      end
      ACT_FRAME: begin
        for (int b = 0; b < NumButtons; b++) begin
          f     = flags_q[b];
          t_ext = CmpW'(ticks_q[b]);
          if (item_i.clear_pressed)  f.pressed  = 1'b0;
          if (item_i.clear_released) f.released = 1'b0;
          if (item_i.clear_held)     f.held     = 1'b0;
          f.dbl = 1'b0;
          // drop waits that ran past the window
          if (t_ext > window_ext) begin
            f.waiting = 1'b0;
          end
          flags_d[b] = f;
        end
        scr_up_d = 1'b0;
        scr_dn_d = 1'b0;
      end
      ACT_TICK: begin
        // saturating tick counters
        for (int b = 0; b < NumButtons; b++) begin
          if (ticks_q[b] != {TickW{1'b1}}) begin
            ticks_d[b] = ticks_q[b] + TickW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields from the updated state
  always_comb begin
    for (int b = 0; b < NumButtons; b++) begin
      result_o.pressed_mask[b]      = flags_d[b].pressed;
      result_o.released_mask[b]     = flags_d[b].released;
      result_o.held_mask[b]         = flags_d[b].held;
      result_o.double_click_mask[b] = flags_d[b].dbl;
    end
    result_o.wheel_up   = scr_up_d;
    result_o.wheel_down = scr_dn_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumButtons; b++) begin
        flags_q[b] <= '0;
        ticks_q[b] <= '0;
      end
      rel_x_q  <= '0;
      rel_y_q  <= '0;
      scr_up_q <= 1'b0;
      scr_dn_q <= 1'b0;
    end else if (apply_i) begin
      for (int b = 0; b < NumButtons; b++) begin
        flags_q[b] <= flags_d[b];
        ticks_q[b] <= ticks_d[b];
      end
      rel_x_q  <= rel_x_d;
      rel_y_q  <= rel_y_d;
      scr_up_q <= scr_up_d;
      scr_dn_q <= scr_dn_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/mouse_button_double_click_tracker_core.sv]
// mouse_button_double_click_tracker_core: top level of the double-click tracker
// depends on mbdct_pkg, mbdct_in_if, mbdct_out_if, mbdct_in_stage, mbdct_update
//
//   port          dir   handshake     contents
//   in_i          sink  valid/ready   action, button, level, position, scroll, clears
//   out_o         src   valid/ready   button masks and scroll flags, one per input
//   cfg_we_i/..   in    write enable  double-click window (16 bits)
//
// each transaction passes through the input register and then the result register;
// one transaction per cycle is sustained while the output is ready.
// the state update sits between the two registers and is applied when the result
// register is free or being drained in the same cycle.
// reset clears all flags, tick counts, stored position and sets the window to 500.
// a stalled output holds both registers; input ready drops only when both are full.
`default_nettype none

module mouse_button_double_click_tracker_core
  import mbdct_pkg::*;
#(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WindowW-1:0] cfg_wdata_i,
  mbdct_in_if.sink                in_i,
  mbdct_out_if.source             out_o
);

  logic    item_valid;
  item_t   item;
  logic    advance;
  result_t result_d;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  // move the held transaction into the result register when it is free
  assign advance = item_valid && (!out_valid_q || out_o.ready);

  mbdct_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  mbdct_update #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .apply_i     (advance),
    .item_i      (item),
    .result_o    (result_d)
  );

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.pressed_mask      = result_q.pressed_mask;
  assign out_o.released_mask     = result_q.released_mask;
  assign out_o.held_mask         = result_q.held_mask;
  assign out_o.double_click_mask = result_q.double_click_mask;
  assign out_o.wheel_up          = result_q.wheel_up;
  assign out_o.wheel_down        = result_q.wheel_down;

endmodule

`default_nettype wire

[sim/testbench.sv]
// testbench: self-checking bench for mouse_button_double_click_tracker_core
// depends on mbdct_pkg, mbdct_in_if, mbdct_out_if and the tracker rtl
// directed table then random clicks, scrolls, frames and ticks under four window settings
`default_nettype none

module testbench
  import mbdct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TickBits = 16;

  // one row of the directed table
  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [WindowW-1:0] cfg_wdata_i;

  mbdct_in_if  in_if ();
  mbdct_out_if out_if ();

  mouse_button_double_click_tracker_core #(
    .TICK_COUNT_BITS(TickBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // tracker state as the bench sees it
  btn_flags_t          btn_state [NumButtons];
  logic [TickBits-1:0] tick_cnt  [NumButtons];
  logic [PosW-1:0]     rel_x, rel_y;
  logic [1:0]          scroll_q;
  logic [WindowW-1:0]  win_q;

  result_t     flags_expected [$];
  dir_row_t    dir_rows [$];
  int          err_cnt   = 0;
  int          n_results = 0;
  int          n_dbl     = 0;
  logic [15:0] cur_x     = '0;
  logic [15:0] cur_y     = '0;

  // apply one transaction to the tracker state and return the flags after it
  function automatic result_t track_step(input item_t it);
    btn_flags_t f;
    result_t    r;
    int         b;
    case (it.action)
      ACT_LEVEL: begin
        if (it.button < NumButtons) begin
          b = it.button;
          f = btn_state[b];
          f.held = it.level;
          if (!f.latched) f.pressed = it.level;
          f.released = !it.level;
          f.latched  = it.level;
          if (f.released) begin
            if (f.allowed) begin
              f.waiting = 1'b1;
              rel_x = it.pos_x;
              rel_y = it.pos_y;
            end else begin
              f.allowed = 1'b1;
            end
            tick_cnt[b] = '0;
          end else if (f.pressed && f.waiting) begin
            if (tick_cnt[b] < win_q && rel_x == it.pos_x && rel_y == it.pos_y)
              f.dbl = 1'b1;
            f.waiting = 1'b0;
            f.allowed = 1'b0;
          end
          btn_state[b] = f;
        end
      end
      ACT_SCROLL: scroll_q = {it.scroll_down, it.scroll_up};
      ACT_FRAME: begin
        for (b = 0; b < NumButtons; b++) begin
          f = btn_state[b];
          if (it.clear_pressed)  f.pressed  = 1'b0;
          if (it.clear_released) f.released = 1'b0;
          if (it.clear_held)     f.held     = 1'b0;
          f.dbl = 1'b0;
          if (tick_cnt[b] > win_q) f.waiting = 1'b0;
          btn_state[b] = f;
        end
        scroll_q = '0;
      end
      default: begin
        for (b = 0; b < NumButtons; b++)
          if (tick_cnt[b] != '1) tick_cnt[b] = tick_cnt[b] + 1'b1;
      end
    endcase
    r = '0;
    for (b = 0; b < NumButtons; b++) begin
      r.pressed_mask[b]      = btn_state[b].pressed;
      r.released_mask[b]     = btn_state[b].released;
      r.held_mask[b]         = btn_state[b].held;
      r.double_click_mask[b] = btn_state[b].dbl;
    end
    r.wheel_up   = scroll_q[0];
    r.wheel_down = scroll_q[1];
    return r;
  endfunction

  // item builders for the directed table
  function automatic item_t lvl(input int btn, input bit level, input int x, input int y);
    item_t it;
    it        = '0;
    it.action = ACT_LEVEL;
    it.button = btn[1:0];
    it.level  = level;
    it.pos_x  = x[15:0];
    it.pos_y  = y[15:0];
    return it;
  endfunction

  function automatic item_t scr(input bit up, input bit down);
    item_t it;
    it             = '0;
    it.action      = ACT_SCROLL;
    it.scroll_up   = up;
    it.scroll_down = down;
    return it;
  endfunction

  function automatic item_t frm(input bit cp, input bit cr, input bit ch);
    item_t it;
    it                = '0;
    it.action         = ACT_FRAME;
    it.clear_pressed  = cp;
    it.clear_released = cr;
    it.clear_held     = ch;
    return it;
  endfunction

  function automatic item_t tck();
    item_t it;
    it        = '0;
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic result_t flags(input logic [2:0] p, input logic [2:0] rl,
                                    input logic [2:0] h, input logic [2:0] d,
                                    input logic su, input logic sd);
    result_t r;
    r.pressed_mask      = p;
    r.released_mask     = rl;
    r.held_mask         = h;
    r.double_click_mask = d;
    r.wheel_up          = su;
    r.wheel_down        = sd;
    return r;
  endfunction

  function automatic dir_row_t row(input item_t it, input bit typed = 1'b0,
                                   input result_t want = '0);
    dir_row_t d;
    d.it    = it;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly press/release runs at the pointer position, mixed with ticks and noise
  function automatic item_t make_random_item();
    item_t       it;
    bit [31:0]   r0, r1;
    int unsigned sel;
    r0 = $urandom;
    r1 = $urandom;
    it.action         = r0[1:0];
    it.button         = r0[3:2];
    it.level          = r0[4];
    it.scroll_up      = r0[5];
    it.scroll_down    = r0[6];
    it.clear_pressed  = r0[7];
    it.clear_released = r0[8];
    it.clear_held     = r0[9];
    it.pos_x          = r1[15:0];
    it.pos_y          = r1[31:16];
    // pointer wanders now and then
    if ($urandom_range(0, 9) == 0) begin
      if (r0[10]) begin
        cur_x = r1[15:0];
        cur_y = r1[31:16];
      end else begin
        cur_x = cur_x + r0[12:11];
        cur_y = cur_y - r0[14:13];
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      it.action = ACT_LEVEL;
      if ($urandom_range(0, 19) == 0) begin
        it.button = 2'd3;
      end else begin
        it.button = 2'($urandom_range(0, NumButtons - 1));
        if ($urandom_range(0, 4) != 0) it.level = !btn_state[it.button].latched;
      end
      if ($urandom_range(0, 9) < 8) begin
        it.pos_x = cur_x;
        it.pos_y = cur_y;
      end
    end else if (sel < 80) begin
      it.action = ACT_TICK;
    end else if (sel < 90) begin
      it.action = ACT_FRAME;
    end else begin
      it.action = ACT_SCROLL;
    end
    return it;
  endfunction

  // offer one transaction and log its expectation when it is taken
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= it.action;
    in_if.button         <= it.button;
    in_if.level          <= it.level;
    in_if.pos_x          <= it.pos_x;
    in_if.pos_y          <= it.pos_y;
    in_if.scroll_up      <= it.scroll_up;
    in_if.scroll_down    <= it.scroll_down;
    in_if.clear_pressed  <= it.clear_pressed;
    in_if.clear_released <= it.clear_released;
    in_if.clear_held     <= it.clear_held;
    do @(posedge clk_i); while (!in_if.ready);
    pred = track_step(it);
    flags_expected.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (flags_expected.size() != 0);
  endtask

  // window update, only with the pipeline empty
  task automatic write_window(input logic [WindowW-1:0] w);
    in_if.valid <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_q = w;
  endtask

  task automatic cmp_field(input string name, input int unsigned want,
                           input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (flags_expected.size() == 0) begin
      $error("result transaction with nothing pending");
      err_cnt++;
      return;
    end
    want = flags_expected.pop_front();
    cmp_field("pressed_mask", want.pressed_mask, got.pressed_mask);
    cmp_field("released_mask", want.released_mask, got.released_mask);
    cmp_field("held_mask", want.held_mask, got.held_mask);
    cmp_field("double_click_mask", want.double_click_mask, got.double_click_mask);
    cmp_field("wheel_up", want.wheel_up, got.wheel_up);
    cmp_field("wheel_down", want.wheel_down, got.wheel_down);
    n_results++;
    if (want.double_click_mask != '0) n_dbl++;
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin : result_sink
    int      stall_left;
    bit      long_done;
    result_t got;
    stall_left = 0;
    long_done  = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.pressed_mask      = out_if.pressed_mask;
        got.released_mask     = out_if.released_mask;
        got.held_mask         = out_if.held_mask;
        got.double_click_mask = out_if.double_click_mask;
        got.wheel_up          = out_if.wheel_up;
        got.wheel_down        = out_if.wheel_down;
        check_result(got);
      end
      if (!long_done && n_results >= 150) begin
        stall_left = 80;
        long_done  = 1'b1;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // stimulus: reset, directed table, then random phases per window
  initial begin : stimulus
    logic [WindowW-1:0] win_list [4];
    int                 ph, k;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    in_if.valid          <= 1'b0;
    in_if.action         <= '0;
    in_if.button         <= '0;
    in_if.level          <= 1'b0;
    in_if.pos_x          <= '0;
    in_if.pos_y          <= '0;
    in_if.scroll_up      <= 1'b0;
    in_if.scroll_down    <= 1'b0;
    in_if.clear_pressed  <= 1'b0;
    in_if.clear_released <= 1'b0;
    in_if.clear_held     <= 1'b0;
    for (k = 0; k < NumButtons; k++) begin
      btn_state[k] = '0;
      tick_cnt[k]  = '0;
    end
    rel_x    = '0;
    rel_y    = '0;
    scroll_q = '0;
    win_q    = WindowRst;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the reset window
    dir_rows.push_back(row(tck(), 1'b1, flags(3'b000, 3'b000, 3'b000, 3'b000, 0, 0)));
    dir_rows.push_back(row(lvl(0, 1, 0, 0), 1'b1,
                           flags(3'b001, 3'b000, 3'b001, 3'b000, 0, 0)));
    dir_rows.push_back(row(lvl(0, 0, -32768, 32767), 1'b1,
                           flags(3'b001, 3'b001, 3'b000, 3'b000, 0, 0)));
    dir_rows.push_back(row(frm(1, 1, 1), 1'b1, flags(3'b000, 3'b000, 3'b000, 3'b000, 0, 0)));
    // button out of range changes nothing
    dir_rows.push_back(row(lvl(3, 1, 5, 5), 1'b1,
                           flags(3'b000, 3'b000, 3'b000, 3'b000, 0, 0)));
    // left double click at the corner position
    dir_rows.push_back(row(lvl(0, 1, -32768, 32767)));
    dir_rows.push_back(row(lvl(0, 0, -32768, 32767)));
    dir_rows.push_back(row(tck()));
    dir_rows.push_back(row(lvl(0, 1, -32768, 32767)));
    dir_rows.push_back(row(scr(1, 1)));
    dir_rows.push_back(row(frm(0, 0, 0)));
    // right button: third press one pixel off, no double click
    dir_rows.push_back(row(lvl(1, 1, 32767, -32768)));
    dir_rows.push_back(row(lvl(1, 0, 32767, -32768)));
    dir_rows.push_back(row(lvl(1, 1, 32767, -32768)));
    dir_rows.push_back(row(lvl(1, 0, 32767, -32768)));
    dir_rows.push_back(row(lvl(1, 1, 32767, -32767)));
    // middle button with a repeated press while latched
    dir_rows.push_back(row(lvl(2, 1, 0, 0)));
    dir_rows.push_back(row(lvl(2, 0, 0, 0)));
    dir_rows.push_back(row(lvl(2, 1, 0, 0)));
    dir_rows.push_back(row(lvl(2, 1, 0, 0)));
    dir_rows.push_back(row(lvl(2, 0, 1, 1)));
    dir_rows.push_back(row(lvl(0, 0, 1, 1)));
    dir_rows.push_back(row(lvl(2, 1, 1, 1)));
    dir_rows.push_back(row(scr(1, 0)));
    dir_rows.push_back(row(scr(0, 1)));
    dir_rows.push_back(row(frm(1, 0, 0)));
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // random phases, window at 1, at its maximum and at two small values
    win_list[0] = 16'd1;
    win_list[1] = 16'hFFFF;
    win_list[2] = WindowW'($urandom_range(2, 12));
    win_list[3] = WindowW'($urandom_range(13, 40));
    for (ph = 0; ph < 4; ph++) begin
      write_window(win_list[ph]);
      for (k = 0; k < 100; k++) begin
        if (ph == 1 && k == 50) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        send_item(make_random_item(), 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("checked %0d result transactions, %0d of them with a double click flagged",
             n_results, n_dbl);
    $display("windows used: 500, 1, 65535, %0d, %0d; long output stall and input pause",
             win_list[2], win_list[3]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("timeout waiting for the tracker");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
